@@ hdl/tge_pkg.sv @@
// Shared request codes, field widths and the memory word layout of the text grid editor.
package tge_pkg;

    // Field widths of the request and result transactions.
    localparam int CODE_W  = 16;
    localparam int COLOR_W = 32;
    localparam int WORD_W  = CODE_W + COLOR_W;
    localparam int STEP_W  = 14;
    localparam int TCOL_W  = 7;
    localparam int TROW_W  = 6;
    localparam int INDEX_W = 13;

    // Request codes.
    localparam logic [2:0] REQ_SET   = 3'd0;
    localparam logic [2:0] REQ_INS   = 3'd1;
    localparam logic [2:0] REQ_DEL   = 3'd2;
    localparam logic [2:0] REQ_MOVR  = 3'd3;
    localparam logic [2:0] REQ_MOVT  = 3'd4;
    localparam logic [2:0] REQ_READ  = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // Character that ends a line during reflow.
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 16'h000A;

endpackage

@@ hdl/text_grid_editor.sv @@
// Top level of the text grid editor: request sequencer, cursor and reflow engine.
//
// Requests arrive on a valid/ready channel and each produces exactly one result
// transaction (read character and cursor position) on a second valid/ready channel.
// The grid lives in a cell memory; insert and delete copy the cells from the cursor
// onward into a scratch memory, emptying them, then write the non-empty ones back.
// Both passes stream one cell per cycle through the registered memory read port.
// Set, move to, read and unused codes finish without a reflow; move relative adds a
// position division, one quotient bit per cycle; insert and delete copy and write back
// the cells from the cursor to the grid end, so they take longest on a full 128 x 64 grid.
// One request is worked on at a time; the next one is accepted as soon as the
// result sits in the output register, even if the receiver has not taken it.
// If the receiver stalls, the finished result waits in the sequencer and no new
// request is accepted until the output register is free.
// After reset the cell memory is cleared one entry per cycle, all MAX_COLS * MAX_ROWS
// entries, while no request is accepted; configuration writes are
// taken at any time and must only be made while the block is idle.
module text_grid_editor
    import tge_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_req_type,
    input  logic [CODE_W-1:0]   i_char_code,
    input  logic [COLOR_W-1:0]  i_char_color,
    input  logic [STEP_W-1:0]   i_step_count,
    input  logic [TCOL_W-1:0]   i_target_col,
    input  logic [TROW_W-1:0]   i_target_row,
    input  logic [INDEX_W-1:0]  i_cell_index,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CODE_W-1:0]   o_read_char,
    output logic [6:0]          o_cursor_col,
    output logic [5:0]          o_cursor_row
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = AW + 1;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int SW    = ((AW > STEP_W - 1) ? AW : STEP_W - 1) + 2;
    localparam int PW    = SW - 1;

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_START    = 13'b0000000000100,
        S_PLACE    = 13'b0000000001000,
        S_LIN      = 13'b0000000010000,
        S_DISPATCH = 13'b0000000100000,
        S_PRE      = 13'b0000001000000,
        S_COPY     = 13'b0000010000000,
        S_WB       = 13'b0000100000000,
        S_FINAL    = 13'b0001000000000,
        S_DIV      = 13'b0010000000000,
        S_RDATA    = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state r_state;

    // Configuration and effective geometry.
    logic [7:0]    r_grid_cols;
    logic [6:0]    r_grid_rows;
    logic [CW-1:0] c_cols;
    logic [RW-1:0] c_rows;
    logic [CW-1:0] r_cols;
    logic [RW-1:0] r_rows;
    logic [LW-1:0] r_size;

    // Captured request.
    logic [2:0]         r_req;
    logic [CODE_W-1:0]  r_code;
    logic [COLOR_W-1:0] r_color;
    logic [STEP_W-1:0]  r_steps;
    logic [TCOL_W-1:0]  r_tcol;
    logic [TROW_W-1:0]  r_trow;
    logic [INDEX_W-1:0] r_idx;

    // Cursor and its linear position.
    logic [CW-1:0] r_cur_col;
    logic [RW-1:0] r_cur_row;
    logic [LW-1:0] r_at;

    // Reflow pipeline.
    logic [LW-1:0] r_ra;
    logic [LW-1:0] r_pa;
    logic          r_pv;
    logic [LW-1:0] r_sw;
    logic [LW-1:0] r_ri;
    logic [CW-1:0] r_wcol;
    logic [RW-1:0] r_wrow;
    logic [LW-1:0] r_wlin;
    logic [LW-1:0] r_clr;

    // Result staging and output register.
    logic [CODE_W-1:0] r_rd;
    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_char;
    logic [6:0]        r_o_col;
    logic [5:0]        r_o_row;

    // Memory ports.
    logic              cell_we;
    logic [AW-1:0]     cell_waddr;
    logic [WORD_W-1:0] cell_wdata;
    logic [AW-1:0]     cell_raddr;
    logic [WORD_W-1:0] cell_rdata;
    logic              scr_we;
    logic [WORD_W-1:0] scr_rdata;

    // Write-back cursor step.
    logic              step_nl;
    logic [CW-1:0]     n_wcol;
    logic [RW-1:0]     n_wrow;
    logic [LW-1:0]     n_wlin;

    // Move relative position and divider.
    logic signed [SW-1:0] mv_sum;
    logic [PW-1:0]        mv_pos;
    logic                 div_start;
    logic                 div_done;
    logic [PW-1:0]        div_quo;
    logic [CW-1:0]        div_rem;

    logic del_req;
    logic out_free;
    logic wb_code_nz;

    assign del_req    = (r_req == REQ_DEL);
    assign out_free   = !r_o_valid || i_out_ready;
    assign wb_code_nz = (scr_rdata[WORD_W-1:COLOR_W] != '0);

    // Register values of zero act as one, values past the maximum act as the maximum.
    always_comb begin
        if (r_grid_cols == '0) begin
            c_cols = CW'(1);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            c_cols = CW'(MAX_COLS);
        end else begin
            c_cols = CW'(r_grid_cols);
        end
        if (r_grid_rows == '0) begin
            c_rows = RW'(1);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            c_rows = RW'(MAX_ROWS);
        end else begin
            c_rows = RW'(r_grid_rows);
        end
    end

    // One cursor step during write-back: next cell, or next row start after a newline.
    // Any step past the grid end stays on the last cell.
    always_comb begin
        step_nl = (r_state == S_PRE) ? (r_code == NEWLINE_CODE)
                                     : (scr_rdata[WORD_W-1:COLOR_W] == NEWLINE_CODE);
        n_wcol = r_cols - CW'(1);
        n_wrow = r_rows - RW'(1);
        n_wlin = r_size - LW'(1);
        if (step_nl) begin
            if ((r_wrow + RW'(1)) < r_rows) begin
                n_wrow = r_wrow + RW'(1);
                n_wcol = '0;
                n_wlin = r_wlin - LW'(r_wcol) + LW'(r_cols);
            end
        end else if ((r_wlin + LW'(1)) < r_size) begin
            n_wlin = r_wlin + LW'(1);
            if ((r_wcol + CW'(1)) == r_cols) begin
                n_wcol = '0;
                n_wrow = r_wrow + RW'(1);
            end else begin
                n_wcol = r_wcol + CW'(1);
                n_wrow = r_wrow;
            end
        end
    end

    // Target position of a relative move, clamped at zero.
    assign mv_sum = $signed({{(SW - LW){1'b0}}, r_at})
                  + $signed({{(SW - STEP_W){r_steps[STEP_W-1]}}, r_steps});
    assign mv_pos = mv_sum[SW-1] ? '0 : mv_sum[PW-1:0];
    assign div_start = (r_state == S_DISPATCH) && (r_req == REQ_MOVR);

    // Cell memory port selection.
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = r_pa[AW-1:0];
        cell_wdata = '0;
        cell_raddr = r_ra[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = r_clr[AW-1:0];
            end
            S_DISPATCH: begin
                cell_raddr = AW'(r_idx);
                if (r_req == REQ_SET) begin
                    cell_we    = 1'b1;
                    cell_waddr = r_at[AW-1:0];
                    cell_wdata = {r_code, r_color};
                end
            end
            S_COPY: begin
                cell_we = r_pv;
            end
            S_WB: begin
                cell_we    = r_pv && wb_code_nz;
                cell_waddr = r_wlin[AW-1:0];
                cell_wdata = scr_rdata;
            end
            S_FINAL: begin
                cell_we    = 1'b1;
                cell_waddr = r_at[AW-1:0];
                cell_wdata = {r_code, r_color};
            end
            default: begin
                cell_we = 1'b0;
            end
        endcase
    end

    // The cell under the cursor is not kept by a delete.
    assign scr_we = (r_state == S_COPY) && r_pv && !(del_req && (r_pa == r_at));

    tge_ram #(
        .W     (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    tge_ram #(
        .W     (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (r_sw[AW-1:0]),
        .i_wdata (cell_rdata),
        .i_raddr (r_ri[AW-1:0]),
        .o_rdata (scr_rdata)
    );

    tge_div #(
        .PW (PW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mv_pos),
        .i_divisor  (r_cols),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 8'd80;
            r_grid_rows <= 7'd25;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLS: r_grid_cols <= i_cfg_data;
                CFG_ROWS: r_grid_rows <= i_cfg_data[6:0];
                default:  r_grid_cols <= r_grid_cols;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_o_valid <= 1'b1;
            r_o_char  <= r_rd;
            r_o_col   <= 7'(r_cur_col);
            r_o_row   <= 6'(r_cur_row);
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_pv      <= 1'b0;
        end else begin
            unique case (r_state)
                // Clearing pass over the cell memory after reset.
                S_CLEAR: begin
                    r_clr <= r_clr + LW'(1);
                    if (r_clr == LW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                // Capture the request transaction.
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_req_type;
                        r_code  <= i_char_code;
                        r_color <= i_char_color;
                        r_steps <= i_step_count;
                        r_tcol  <= i_target_col;
                        r_trow  <= i_target_row;
                        r_idx   <= i_cell_index;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_cols  <= c_cols;
                    r_rows  <= c_rows;
                    r_state <= S_PLACE;
                end
                // Bring the cursor back inside the current geometry.
                S_PLACE: begin
                    r_size <= LW'(r_cols) * LW'(r_rows);
                    if (r_cur_row >= r_rows) begin
                        r_cur_row <= r_rows - RW'(1);
                        r_cur_col <= r_cols - CW'(1);
                    end else if (r_cur_col >= r_cols) begin
                        r_cur_col <= r_cols - CW'(1);
                    end
                    r_state <= S_LIN;
                end
                S_LIN: begin
                    r_at    <= LW'(r_cur_row) * LW'(r_cols) + LW'(r_cur_col);
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_rd    <= '0;
                    r_ra    <= r_at;
                    r_sw    <= '0;
                    r_pv    <= 1'b0;
                    r_wcol  <= r_cur_col;
                    r_wrow  <= r_cur_row;
                    r_wlin  <= r_at;
                    case (r_req)
                        REQ_INS: r_state <= S_PRE;
                        REQ_DEL: r_state <= S_COPY;
                        REQ_MOVR: r_state <= S_DIV;
                        REQ_MOVT: begin
                            if (int'(r_trow) >= int'(r_rows)) begin
                                r_cur_row <= r_rows - RW'(1);
                                r_cur_col <= r_cols - CW'(1);
                            end else begin
                                r_cur_row <= RW'(r_trow);
                                r_cur_col <= (int'(r_tcol) >= int'(r_cols))
                                           ? r_cols - CW'(1) : CW'(r_tcol);
                            end
                            r_state <= S_DONE;
                        end
                        REQ_READ: begin
                            if (int'(r_idx) < int'(r_size)) begin
                                r_state <= S_RDATA;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                // An insert writes back from one step past the cursor.
                S_PRE: begin
                    r_wcol  <= n_wcol;
                    r_wrow  <= n_wrow;
                    r_wlin  <= n_wlin;
                    r_state <= S_COPY;
                end
                // Move the cells from the cursor to the grid end into scratch, emptying them.
                S_COPY: begin
                    if (r_ra < r_size) begin
                        r_pv <= 1'b1;
                        r_pa <= r_ra;
                        r_ra <= r_ra + LW'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (scr_we) begin
                        r_sw <= r_sw + LW'(1);
                    end
                    if ((r_ra >= r_size) && !r_pv) begin
                        r_ri    <= '0;
                        r_state <= S_WB;
                    end
                end
                // Write the non-empty scratch cells back in order.
                S_WB: begin
                    if (r_ri < r_sw) begin
                        r_pv <= 1'b1;
                        r_ri <= r_ri + LW'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && wb_code_nz) begin
                        r_wcol <= n_wcol;
                        r_wrow <= n_wrow;
                        r_wlin <= n_wlin;
                    end
                    if ((r_ri >= r_sw) && !r_pv) begin
                        r_state <= del_req ? S_DONE : S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_state <= S_DONE;
                end
                // Split the linear position into row and column.
                S_DIV: begin
                    if (div_done) begin
                        if (int'(div_quo) >= int'(r_rows)) begin
                            r_cur_row <= r_rows - RW'(1);
                            r_cur_col <= r_cols - CW'(1);
                        end else begin
                            r_cur_row <= RW'(div_quo);
                            r_cur_col <= div_rem;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_RDATA: begin
                    r_rd    <= cell_rdata[WORD_W-1:COLOR_W];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_read_char  = r_o_char;
    assign o_cursor_col = r_o_col;
    assign o_cursor_row = r_o_row;

endmodule

@@ hdl/tge_ram.sv @@
// Simple dual-port synchronous memory with one write port and one registered read port.
module tge_ram
    import tge_pkg::*;
#(
    parameter int W     = WORD_W,
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tge_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module tge_div #(
    parameter int PW = 16,
    parameter int CW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [PW-1:0] o_quo,
    output logic [CW-1:0] o_rem
);

    localparam int NW = $clog2(PW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [PW-1:0] r_quo;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;
    logic [CW:0]   trial;
    logic          ge;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign trial = {r_rem, r_quo[PW-1]};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == NW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(PW);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? CW'(trial - {1'b0, r_div}) : CW'(trial);
                r_quo <= {r_quo[PW-2:0], ge};
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ verif/text_grid_editor_checker.sv @@
// Checker for the text grid editor: grid predictor, result queue and comparison.
module text_grid_editor_checker
    import tge_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [2:0]          i_req_type,
    input  logic [CODE_W-1:0]   i_char_code,
    input  logic [COLOR_W-1:0]  i_char_color,
    input  logic [STEP_W-1:0]   i_step_count,
    input  logic [TCOL_W-1:0]   i_target_col,
    input  logic [TROW_W-1:0]   i_target_row,
    input  logic [INDEX_W-1:0]  i_cell_index,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [CODE_W-1:0]   i_read_char,
    input  logic [6:0]          i_cursor_col,
    input  logic [5:0]          i_cursor_row,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;

    typedef struct packed {
        logic [CODE_W-1:0] rd;
        logic [6:0]        col;
        logic [5:0]        row;
    } t_cursor_result;

    logic [WORD_W-1:0] grid_cells [DEPTH];
    logic [WORD_W-1:0] spill_cells [DEPTH];
    int unsigned reg_cols, reg_rows;
    int unsigned pos_col, pos_row;
    int unsigned cols, rows, area;
    t_cursor_result result_queue [$];

    // Cursor placement with clamping to the last column or last cell.
    function automatic void put_xy(int unsigned x, int unsigned y);
        if (y >= rows) begin
            pos_row = rows - 1;
            pos_col = cols - 1;
        end else begin
            pos_row = y;
            pos_col = (x >= cols) ? cols - 1 : x;
        end
    endfunction

    function automatic void put_lin(int unsigned p);
        put_xy(p % cols, p / cols);
    endfunction

    // Empty the cells from 'from' onward, then write the non-empty ones back from 'dest'.
    function automatic void reflow_cells(int unsigned from, int unsigned dest);
        int unsigned n;
        int unsigned p;
        logic [CODE_W-1:0] c;
        n = area - from;
        for (int unsigned i = 0; i < n; i++) begin
            spill_cells[i] = grid_cells[from + i];
            grid_cells[from + i] = '0;
        end
        put_lin(dest);
        for (int unsigned i = 0; i < n; i++) begin
            c = spill_cells[i][WORD_W-1:COLOR_W];
            if (c != 0) begin
                p = pos_row * cols + pos_col;
                if (p < area) grid_cells[p] = spill_cells[i];
                if (c != NEWLINE_CODE) put_lin(p + 1);
                else put_lin((pos_row + 1) * cols);
            end
        end
    endfunction

    // Apply one request to the predicted grid and return the expected result.
    function automatic t_cursor_result apply_request(logic [2:0] req, logic [CODE_W-1:0] code,
            logic [COLOR_W-1:0] color, logic signed [STEP_W-1:0] steps,
            logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow, logic [INDEX_W-1:0] idx);
        t_cursor_result r;
        int unsigned at;
        int p;
        r.rd = '0;
        cols = (reg_cols < 1) ? 1 : ((reg_cols > MAX_COLS) ? MAX_COLS : reg_cols);
        rows = (reg_rows < 1) ? 1 : ((reg_rows > MAX_ROWS) ? MAX_ROWS : reg_rows);
        area = cols * rows;
        put_xy(pos_col, pos_row);
        at = pos_row * cols + pos_col;
        case (req)
            REQ_SET: begin
                grid_cells[at] = {code, color};
            end
            REQ_INS: begin
                reflow_cells(at, (code == NEWLINE_CODE) ? (pos_row + 1) * cols : at + 1);
                grid_cells[at] = {code, color};
                put_lin(at);
            end
            REQ_DEL: begin
                grid_cells[at] = '0;
                reflow_cells(at + 1, at);
                put_lin(at);
            end
            REQ_MOVR: begin
                p = int'(at) + int'(steps);
                if (p < 0) p = 0;
                put_lin(p);
            end
            REQ_MOVT: begin
                put_xy(tcol, trow);
            end
            REQ_READ: begin
                if (idx < area) r.rd = grid_cells[idx][WORD_W-1:COLOR_W];
            end
            default: begin
            end
        endcase
        r.col = pos_col[6:0];
        r.row = pos_row[5:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    assign o_pending = result_queue.size();

    // Track register writes and request transactions; compare each result transaction.
    always @(posedge i_clk) begin
        t_cursor_result want;
        if (!i_rst_n) begin
            reg_cols <= 80;
            reg_rows <= 25;
            pos_col = 0;
            pos_row = 0;
            for (int i = 0; i < DEPTH; i++) grid_cells[i] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COLS) reg_cols <= i_cfg_data;
                else reg_rows <= {1'b0, i_cfg_data[6:0]};
            end
            if (i_in_valid && i_in_ready)
                result_queue.push_back(apply_request(i_req_type, i_char_code, i_char_color,
                    i_step_count, i_target_col, i_target_row, i_cell_index));
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (result_queue.size() == 0) begin
                    report_mismatch("result transactions", o_checked, o_checked - 1);
                end else begin
                    want = result_queue.pop_front();
                    if (i_read_char !== want.rd)
                        report_mismatch("read_char", i_read_char, want.rd);
                    if (i_cursor_col !== want.col)
                        report_mismatch("cursor_col", i_cursor_col, want.col);
                    if (i_cursor_row !== want.row)
                        report_mismatch("cursor_row", i_cursor_row, want.row);
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end
endmodule

@@ verif/text_grid_editor_tb.sv @@
// Testbench top for the text grid editor: clock, reset, stimulus and verdict.
module text_grid_editor_tb;
    import tge_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_idx;
    logic [7:0]          i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [2:0]          i_req_type;
    logic [CODE_W-1:0]   i_char_code;
    logic [COLOR_W-1:0]  i_char_color;
    logic [STEP_W-1:0]   i_step_count;
    logic [TCOL_W-1:0]   i_target_col;
    logic [TROW_W-1:0]   i_target_row;
    logic [INDEX_W-1:0]  i_cell_index;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [CODE_W-1:0]   o_read_char;
    logic [6:0]          o_cursor_col;
    logic [5:0]          o_cursor_row;
    int                  fail_count;
    int                  pending;
    int                  checked;
    longint              cycle_count;
    bit                  hold_off;
    int                  sent;

    text_grid_editor uut (.*);

    text_grid_editor_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_req_type, .i_char_code, .i_char_color,
        .i_step_count, .i_target_col, .i_target_row, .i_cell_index,
        .i_out_valid(o_out_valid), .i_out_ready, .i_read_char(o_read_char),
        .i_cursor_col(o_cursor_col), .i_cursor_row(o_cursor_row),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: random stalls, with one long hold-off on request.
    initial begin
        int gap;
        i_out_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_out_ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Offer one request transaction after a random gap and wait for acceptance.
    task automatic send_request(logic [2:0] req, logic [CODE_W-1:0] code,
            logic [COLOR_W-1:0] color, logic [STEP_W-1:0] steps, logic [TCOL_W-1:0] tcol,
            logic [TROW_W-1:0] trow, logic [INDEX_W-1:0] idx, bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1;
        i_req_type   <= req;
        i_char_code  <= code;
        i_char_color <= color;
        i_step_count <= steps;
        i_target_col <= tcol;
        i_target_row <= trow;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drop_valid();
        i_in_valid <= 0;
        @(posedge i_clk);
    endtask

    // Wait for every expected result, then for the block to settle.
    task automatic drain_block();
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // Random content: mostly printable text and newlines, sometimes any code.
    function automatic logic [CODE_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1:    return NEWLINE_CODE;
            2:       return 16'($urandom);
            3:       return '0;
            default: return 16'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // A random request, weighted toward text editing near the cursor.
    task automatic random_request();
        logic [2:0] req;
        logic [STEP_W-1:0] steps;
        case ($urandom_range(0, 11))
            0, 1, 2: req = REQ_INS;
            3, 4:    req = REQ_SET;
            5, 6:    req = REQ_DEL;
            7:       req = REQ_MOVR;
            8:       req = REQ_MOVT;
            9, 10:   req = REQ_READ;
            default: req = 3'($urandom_range(6, 7));
        endcase
        steps = ($urandom_range(0, 1) == 0) ? 14'($signed($urandom_range(0, 40)) - 20)
                                            : 14'($urandom);
        send_request(req, pick_char(), $urandom, steps, 7'($urandom), 6'($urandom),
            ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 60)), 0);
    endtask

    initial begin
        int ncols [4];
        int nrows [4];
        ncols = '{8, 1, 5, 0};
        nrows = '{4, 1, 127, 3};
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        i_in_valid = 0; i_req_type = 0; i_char_code = 0; i_char_color = 0;
        i_step_count = 0; i_target_col = 0; i_target_row = 0; i_cell_index = 0;
        hold_off = 0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset geometry, extremes of every field and operation.
        send_request(REQ_READ, 0, 0, 0, 0, 0, 13'h1FFF, 0);
        send_request(REQ_SET, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        send_request(REQ_MOVT, 0, 0, 0, 7'h7F, 6'd3, 0, 0);
        send_request(REQ_INS, 16'h0041, 32'h1234_5678, 0, 0, 0, 0, 0);
        send_request(REQ_MOVT, 0, 0, 0, 0, 6'h3F, 0, 0);
        send_request(REQ_INS, 16'h0042, 32'h0, 0, 0, 0, 0, 0);
        send_request(REQ_MOVT, 0, 0, 0, 7'd2, 0, 0, 0);
        send_request(REQ_INS, NEWLINE_CODE, 32'hA5A5_A5A5, 0, 0, 0, 0, 0);
        send_request(REQ_INS, 16'h0000, 32'h5A5A_5A5A, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 13'd80, 0);
        send_request(REQ_MOVR, 0, 0, 14'h1FFF, 0, 0, 0, 0);
        send_request(REQ_MOVR, 0, 0, 14'h2000, 0, 0, 0, 0);
        send_request(REQ_DEL, 0, 0, 0, 0, 0, 0, 0);
        send_request(REQ_DEL, 0, 0, 0, 0, 0, 0, 0);
        send_request(3'd6, 16'h1, 0, 0, 0, 0, 0, 0);
        send_request(3'd7, 0, 0, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 13'd1999, 0);
        drop_valid();
        drain_block();

        // Random phases over several geometries, including zero and oversize values.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_COLS, 8'(ncols[ph]));
            write_reg(CFG_ROWS, 8'(nrows[ph]));
            for (int k = 0; k < 20; k++) random_request();
            if (ph == 1) begin
                // Long receiver stall while requests keep coming.
                hold_off = 1;
                for (int k = 0; k < 6; k++)
                    send_request(REQ_READ, 0, 0, 0, 0, 0, 13'($urandom_range(0, 3)), 1);
            end
            drop_valid();
            drain_block();
        end
        write_reg(CFG_COLS, 8'hFF);
        write_reg(CFG_ROWS, 8'h7F);
        for (int k = 0; k < 4; k++) random_request();
        drop_valid();
        drain_block();
        write_reg(CFG_COLS, 8'd128);
        write_reg(CFG_ROWS, 8'd64);
        send_request(REQ_MOVT, 0, 0, 0, 7'd127, 6'd63, 0, 0);
        send_request(REQ_INS, 16'h0043, 32'h1, 0, 0, 0, 0, 0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 13'h1FFF, 0);
        send_request(REQ_MOVR, 0, 0, 14'h2000, 0, 0, 0, 0);
        drop_valid();
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results across six grid geometries,",
            sent, checked);
        $display("including degenerate sizes, a newline-heavy reflow mix and a long stall.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
